>>> rtl/core/fixed_frame_sync_decoder_top_assert.svh
// Assertion macros for the frame sync decoder.
// The enclosing module must provide clk_i and rst_ni.
`ifndef FIXED_FRAME_SYNC_DECODER_TOP_ASSERT_SVH
`define FIXED_FRAME_SYNC_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define FSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fsd assertion failed");

// Checked at every edge, also during reset.
`define FSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("fsd assertion failed");

`else

`define FSD_ASSERT(lbl, prop)
`define FSD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/fsd_pkg.sv
package fsd_pkg;

  localparam int FrameLen = 26;            // bytes per frame, 25..64
  localparam int LastIdx  = FrameLen - 1;  // trailer position
  localparam int FillW    = $clog2(FrameLen);

  localparam logic [7:0] HdrA    = 8'd104;
  localparam logic [7:0] HdrB    = 8'd19;
  localparam logic [7:0] Trailer = 8'd22;

  typedef struct packed {
    logic [7:0]  watchdog_byte;
    logic [7:0]  status_byte;
    logic [7:0]  error_byte;
    logic [15:0] temperature;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] power;
    logic [15:0] flow_rate;
    logic [31:0] timestamp;
    logic [31:0] skipped_count;
    logic [31:0] valid_count;
  } fsd_result_t;

endpackage

>>> rtl/core/fsd_if.sv
interface fsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  watchdog_byte;
  logic [7:0]  status_byte;
  logic [7:0]  error_byte;
  logic [15:0] temperature;
  logic [15:0] voltage;
  logic [15:0] current;
  logic [15:0] power;
  logic [15:0] flow_rate;
  logic [31:0] timestamp;
  logic [31:0] skipped_count;
  logic [31:0] valid_count;

  modport source (
    output valid, output watchdog_byte, output status_byte, output error_byte,
    output temperature, output voltage, output current, output power,
    output flow_rate, output timestamp, output skipped_count, output valid_count,
    input ready
  );
  modport sink (
    input valid, input watchdog_byte, input status_byte, input error_byte,
    input temperature, input voltage, input current, input power,
    input flow_rate, input timestamp, input skipped_count, input valid_count,
    output ready
  );
endinterface

>>> rtl/core/fsd_window.sv
`include "fixed_frame_sync_decoder_top_assert.svh"

module fsd_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic                out_busy_i,
  output logic                ready_o,
  output logic                load_o,
  output fsd_pkg::fsd_result_t res_o
);

  logic [7:0]                win_q [fsd_pkg::LastIdx];
  logic [fsd_pkg::FillW-1:0] fill_q, fill_d;
  logic [31:0]               skip_q, skip_d;
  logic [31:0]               frame_q, frame_d;

  logic accept, last, complete, match, hit, miss;

  assign last     = (fill_q == fsd_pkg::FillW'(fsd_pkg::LastIdx));
  // only the closing byte can yield a result, so only it waits on a busy output
  assign ready_o  = !last || !out_busy_i;
  assign accept   = valid_i && ready_o;
  assign complete = accept && last;
  assign match    = (win_q[0] == fsd_pkg::HdrA) && (win_q[1] == fsd_pkg::HdrB) &&
                    (win_q[2] == fsd_pkg::HdrB) && (win_q[3] == fsd_pkg::HdrA) &&
                    (win_q[4] == fsd_pkg::HdrB) && (byte_i == fsd_pkg::Trailer);
  assign hit      = complete && match;
  assign miss     = complete && !match;
  assign load_o   = hit;

  always_comb begin
    fill_d  = fill_q;
    skip_d  = skip_q;
    frame_d = frame_q;
    if (hit) begin
      fill_d  = '0;
      frame_d = frame_q + 32'd1;
    end else if (miss) begin
      skip_d  = skip_q + 32'd1;            // drop oldest, stay one short of full
    end else if (accept) begin
      fill_d  = fill_q + fsd_pkg::FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      skip_q  <= '0;
      frame_q <= '0;
    end else begin
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      frame_q <= frame_d;
    end
  end

  for (genvar i = 0; i < fsd_pkg::LastIdx; i++) begin : g_win
    logic [7:0] shift_in;
    if (i == fsd_pkg::LastIdx - 1) begin : g_top
      assign shift_in = byte_i;
    end else begin : g_mid
      assign shift_in = win_q[i+1];
    end
    always_ff @(posedge clk_i) begin
      if (miss) begin
        win_q[i] <= shift_in;
      end else if (accept && fill_q == fsd_pkg::FillW'(i)) begin
        win_q[i] <= byte_i;
      end
    end
  end

  always_comb begin
    res_o.watchdog_byte = win_q[5];
    res_o.status_byte   = win_q[6];
    res_o.error_byte    = win_q[7];
    res_o.temperature   = {win_q[10], win_q[11]};
    res_o.voltage       = {win_q[12], win_q[13]};
    res_o.current       = {win_q[14], win_q[15]};
    res_o.power         = {win_q[16], win_q[17]};
    res_o.flow_rate     = {win_q[18], win_q[19]};
    res_o.timestamp     = {win_q[20], win_q[21], win_q[22], win_q[23]};
    res_o.skipped_count = skip_q;
    res_o.valid_count   = frame_q + 32'd1;
  end

  `FSD_ASSERT(a_fill_range, fill_q <= fsd_pkg::FillW'(fsd_pkg::LastIdx))
  `FSD_ASSERT(a_hit_clears, hit |=> fill_q == '0 && frame_q == $past(frame_q) + 32'd1)
  `FSD_ASSERT(a_miss_skips,
    miss |=> last && skip_q == $past(skip_q) + 32'd1 && frame_q == $past(frame_q))
  `FSD_ASSERT(a_busy_stall, out_busy_i && last |-> !ready_o && !load_o)

endmodule

>>> rtl/core/fsd_out_reg.sv
module fsd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fsd_pkg::fsd_result_t res_i,
  output logic                 busy_o,
  fsd_out_if.source            out_o
);

  logic                 valid_q;
  fsd_pkg::fsd_result_t res_q;

  assign busy_o = valid_q && !out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.watchdog_byte = res_q.watchdog_byte;
  assign out_o.status_byte   = res_q.status_byte;
  assign out_o.error_byte    = res_q.error_byte;
  assign out_o.temperature   = res_q.temperature;
  assign out_o.voltage       = res_q.voltage;
  assign out_o.current       = res_q.current;
  assign out_o.power         = res_q.power;
  assign out_o.flow_rate     = res_q.flow_rate;
  assign out_o.timestamp     = res_q.timestamp;
  assign out_o.skipped_count = res_q.skipped_count;
  assign out_o.valid_count   = res_q.valid_count;

endmodule

>>> rtl/core/fixed_frame_sync_decoder_top.sv
// Fixed-length frame deframer: takes one received byte per beat, one beat
// per cycle, into a window of fsd_pkg::FrameLen bytes. Once the window is
// full it checks the header 104,19,19,104,19 and the trailer 22. A match
// delivers one decoded frame beat (status bytes, five big-endian 16-bit
// readings, a 32-bit time stamp, skip and valid counts) in the cycle after
// the closing byte and empties the window; a mismatch drops the oldest byte
// and bumps the skip count, so resync advances one byte per beat. Counters
// wrap at 32 bits. Throughput is one byte per cycle; the only stall is a
// closing byte arriving while the single output register still holds an
// untaken frame. The window needs no reset: it is only decoded once full.

module fixed_frame_sync_decoder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fsd_in_if.sink    in_i,
  fsd_out_if.source out_o
);

  // result path between the window and the output register
  fsd_pkg::fsd_result_t res;
  logic                 load;
  logic                 out_busy;

  // window shift register, header/trailer check, counters and field decode
  fsd_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .byte_i     (in_i.rx_byte),
    .out_busy_i (out_busy),
    .ready_o    (in_i.ready),
    .load_o     (load),
    .res_o      (res)
  );

  // output register; holds the decoded frame until the output handshake takes it
  fsd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .res_i  (res),
    .busy_o (out_busy),
    .out_o  (out_o)
  );

endmodule
